// ===== rtl/env_comp_pkg.sv =====
// ----------------------------------------------------------------------------
// Environmental sensor compensation package
// Shared constants, register indexes, pipeline record and 32-bit helpers.
// ----------------------------------------------------------------------------
package env_comp_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 64;
   localparam int unsigned DivBits       = 32;
   localparam int unsigned DivFirst      = 11;
   localparam int unsigned NumStages     = DivFirst + DivBits + 4;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_TEMP    = 3'd0,
      REG_PRESS_A = 3'd1,
      REG_PRESS_B = 3'd2,
      REG_PRESS_9 = 3'd3,
      REG_HUM_A   = 3'd4,
      REG_HUM_B   = 3'd5
   } reg_index_type;

   localparam logic [31:0] PressOffset = 32'd64000;
   localparam logic [31:0] HumOffset   = 32'd76800;
   localparam logic [31:0] PressBase   = 32'd1048576;
   localparam logic [31:0] PressScale  = 32'd3125;
   localparam logic [31:0] HumRound    = 32'd16384;
   localparam logic [31:0] HumBias     = 32'd32768;
   localparam logic [31:0] HumY0       = 32'd2097152;
   localparam logic [31:0] HumYRound   = 32'd8192;
   localparam logic [31:0] HumMax      = 32'd419430400;

   typedef struct packed {
      logic        vld;
      logic [19:0] adc_t;
      logic [19:0] adc_p;
      logic [15:0] adc_h;
      logic [31:0] fine;
      logic [31:0] temp;
      logic [31:0] pa;
      logic [31:0] v;
      logic [31:0] t0;
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [31:0] t4;
      logic [31:0] t5;
      logic [31:0] t6;
      logic [31:0] x;
      logic [31:0] pb;
      logic [31:0] den;
      logic        big;
      logic [31:0] rem;
      logic [31:0] nq;
      logic [31:0] p;
      logic [31:0] press;
      logic [16:0] hum;
      logic        flag;
   } pipe_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] r;
      r = a * b;
      return r[31:0];
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

// ===== rtl/env_sensor_compensation_core.sv =====
// ----------------------------------------------------------------------------
// Environmental sensor compensation core
// Each sample runs through the pipeline to the rsp_valid strobe; one sample may
// start in every cycle, so busy is never raised and throughput is one per
// cycle. The length is set mainly by the 32-stage pipelined restoring divider.
// Synchronous reset clears all coefficients to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module env_sensor_compensation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [19:0] req_raw_temp,
   input  logic [19:0] req_raw_press,
   input  logic [15:0] req_raw_hum,
   input  logic        csr_we,
   input  logic [env_comp_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [env_comp_pkg::CsrDataWidth-1:0]  csr_wdata,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_temp_centi,
   output logic [31:0] rsp_press_pascal,
   output logic [16:0] rsp_hum_milli,
   output logic        rsp_press_div_zero
);

   localparam int unsigned NS = env_comp_pkg::NumStages;
   localparam int unsigned DF = env_comp_pkg::DivFirst;
   localparam int unsigned DL = env_comp_pkg::DivFirst + env_comp_pkg::DivBits;

   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [15:0] press_9_ff;
   logic [31:0] hum_a_ff;
   logic [31:0] hum_b_ff;

   env_comp_pkg::pipe_type st_ff [NS];
   env_comp_pkg::pipe_type st_in [NS];

   logic [31:0] c_t1, c_t2, c_t3, c_p1, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;
   logic [31:0] c_h1, c_h2, c_h3, c_h4, c_h5, c_h6;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         press_9_ff     <= '0;
         hum_a_ff       <= '0;
         hum_b_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            env_comp_pkg::REG_TEMP:    temp_coeffs_ff <= csr_wdata[47:0];
            env_comp_pkg::REG_PRESS_A: press_a_ff     <= csr_wdata;
            env_comp_pkg::REG_PRESS_B: press_b_ff     <= csr_wdata;
            env_comp_pkg::REG_PRESS_9: press_9_ff     <= csr_wdata[15:0];
            env_comp_pkg::REG_HUM_A:   hum_a_ff       <= csr_wdata[31:0];
            env_comp_pkg::REG_HUM_B:   hum_b_ff       <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign c_t1 = {16'd0, temp_coeffs_ff[15:0]};
   assign c_t2 = env_comp_pkg::sext16(temp_coeffs_ff[31:16]);
   assign c_t3 = env_comp_pkg::sext16(temp_coeffs_ff[47:32]);
   assign c_p1 = {16'd0, press_a_ff[15:0]};
   assign c_p2 = env_comp_pkg::sext16(press_a_ff[31:16]);
   assign c_p3 = env_comp_pkg::sext16(press_a_ff[47:32]);
   assign c_p4 = env_comp_pkg::sext16(press_a_ff[63:48]);
   assign c_p5 = env_comp_pkg::sext16(press_b_ff[15:0]);
   assign c_p6 = env_comp_pkg::sext16(press_b_ff[31:16]);
   assign c_p7 = env_comp_pkg::sext16(press_b_ff[47:32]);
   assign c_p8 = env_comp_pkg::sext16(press_b_ff[63:48]);
   assign c_p9 = env_comp_pkg::sext16(press_9_ff);
   assign c_h1 = {24'd0, hum_a_ff[7:0]};
   assign c_h2 = env_comp_pkg::sext16(hum_a_ff[23:8]);
   assign c_h3 = {24'd0, hum_a_ff[31:24]};
   assign c_h4 = {20'd0, hum_b_ff[11:0]};
   assign c_h5 = {20'd0, hum_b_ff[23:12]};
   assign c_h6 = {{24{hum_b_ff[31]}}, hum_b_ff[31:24]};

   always_comb begin
      logic [32:0] r33;
      logic [26:0] hp;
      logic [31:0] z;
      st_in[0]       = st_ff[0];
      st_in[0].vld   = start;
      st_in[0].adc_t = req_raw_temp;
      st_in[0].adc_p = req_raw_press;
      st_in[0].adc_h = req_raw_hum;
      for (int k = 1; k < NS; k++) begin
         st_in[k] = st_ff[k-1];
      end

      // Temperature.
      st_in[1].t0 = env_comp_pkg::mul({15'd0, st_ff[0].adc_t[19:3]} - (c_t1 << 1), c_t2);
      st_in[1].t1 = env_comp_pkg::mul({16'd0, st_ff[0].adc_t[19:4]} - c_t1,
                                      {16'd0, st_ff[0].adc_t[19:4]} - c_t1);
      st_in[2].t0 = env_comp_pkg::asr(st_ff[1].t0, 11);
      st_in[2].t1 = env_comp_pkg::mul(env_comp_pkg::asr(st_ff[1].t1, 12), c_t3);
      st_in[3].fine = st_ff[2].t0 + env_comp_pkg::asr(st_ff[2].t1, 14);
      st_in[4].temp = env_comp_pkg::asr((st_ff[3].fine << 2) + st_ff[3].fine + 32'd128, 8);
      st_in[4].pa = env_comp_pkg::asr(st_ff[3].fine, 1) - env_comp_pkg::PressOffset;
      st_in[4].v  = st_ff[3].fine - env_comp_pkg::HumOffset;

      // Pressure numerator and divisor, humidity front end.
      st_in[5].t0 = env_comp_pkg::mul(env_comp_pkg::asr(st_ff[4].pa, 2),
                                      env_comp_pkg::asr(st_ff[4].pa, 2));
      st_in[5].t1 = env_comp_pkg::mul(st_ff[4].pa, c_p5);
      st_in[5].t2 = env_comp_pkg::mul(c_p2, st_ff[4].pa);
      st_in[5].t3 = env_comp_pkg::mul(c_h5, st_ff[4].v);
      st_in[5].t4 = env_comp_pkg::mul(st_ff[4].v, c_h6);
      st_in[5].t5 = env_comp_pkg::mul(st_ff[4].v, c_h3);
      st_in[6].t0 = env_comp_pkg::mul(env_comp_pkg::asr(st_ff[5].t0, 11), c_p6);
      st_in[6].t6 = env_comp_pkg::mul(c_p3, env_comp_pkg::asr(st_ff[5].t0, 13));
      st_in[6].x  = env_comp_pkg::asr(({16'd0, st_ff[5].adc_h} << 14) - (c_h4 << 20)
                                      - st_ff[5].t3 + env_comp_pkg::HumRound, 15);
      st_in[6].t4 = env_comp_pkg::mul(env_comp_pkg::asr(st_ff[5].t4, 10),
                                      env_comp_pkg::asr(st_ff[5].t5, 11) + env_comp_pkg::HumBias);
      st_in[7].pb = env_comp_pkg::asr(st_ff[6].t0 + (st_ff[6].t1 << 1), 2) + (c_p4 << 16);
      st_in[7].t2 = env_comp_pkg::asr(env_comp_pkg::asr(st_ff[6].t6, 3)
                                      + env_comp_pkg::asr(st_ff[6].t2, 1), 18);
      st_in[7].t4 = env_comp_pkg::asr(st_ff[6].t4, 10) + env_comp_pkg::HumY0;
      st_in[8].t2 = env_comp_pkg::mul(32'd32768 + st_ff[7].t2, c_p1);
      st_in[8].pb = env_comp_pkg::PressBase - {12'd0, st_ff[7].adc_p}
                    - env_comp_pkg::asr(st_ff[7].pb, 12);
      st_in[8].t4 = env_comp_pkg::mul(st_ff[7].t4, c_h2);
      st_in[9].den = env_comp_pkg::asr(st_ff[8].t2, 15);
      st_in[9].pb  = env_comp_pkg::mul(st_ff[8].pb, env_comp_pkg::PressScale);
      st_in[9].t4  = env_comp_pkg::asr(st_ff[8].t4 + env_comp_pkg::HumYRound, 14);
      st_in[10].big = st_ff[9].pb[31];
      st_in[10].rem = '0;
      st_in[10].nq  = st_ff[9].pb[31] ? st_ff[9].pb : (st_ff[9].pb << 1);
      st_in[10].t4  = env_comp_pkg::mul(st_ff[9].x, st_ff[9].t4);

      // Humidity tail.
      st_in[11].t5 = env_comp_pkg::asr(st_ff[10].t4, 15);
      st_in[12].t5 = env_comp_pkg::mul(st_ff[11].t5, st_ff[11].t5);
      st_in[13].t5 = env_comp_pkg::mul(env_comp_pkg::asr(st_ff[12].t5, 7), c_h1);
      z = st_ff[13].t4 - env_comp_pkg::asr(st_ff[13].t5, 4);
      if (z[31]) begin
         z = '0;
      end else if (z > env_comp_pkg::HumMax) begin
         z = env_comp_pkg::HumMax;
      end
      st_in[14].t4 = z;
      hp = {10'd0, st_ff[14].t4[28:12]} * 27'd1000;
      st_in[15].hum = hp[26:10];

      // Restoring divider, one quotient bit per stage.
      for (int k = DF; k < DL; k++) begin
         r33 = {st_ff[k-1].rem, st_ff[k-1].nq[31]};
         st_in[k].nq = {st_ff[k-1].nq[30:0], 1'b0};
         if (r33 >= {1'b0, st_ff[k-1].den}) begin
            r33 = r33 - {1'b0, st_ff[k-1].den};
            st_in[k].nq[0] = 1'b1;
         end
         st_in[k].rem = r33[31:0];
      end

      // Pressure correction.
      st_in[DL].p = st_ff[DL-1].big ? (st_ff[DL-1].nq << 1) : st_ff[DL-1].nq;
      st_in[DL+1].t0 = env_comp_pkg::mul(st_ff[DL].p >> 3, st_ff[DL].p >> 3);
      st_in[DL+1].t1 = env_comp_pkg::mul(st_ff[DL].p >> 2, c_p8);
      st_in[DL+2].t0 = env_comp_pkg::mul(c_p9, st_ff[DL+1].t0 >> 13);
      st_in[DL+3].flag = (st_ff[DL+2].den == '0);
      st_in[DL+3].press = (st_ff[DL+2].den == '0) ? '0 :
         st_ff[DL+2].p + env_comp_pkg::asr(env_comp_pkg::asr(st_ff[DL+2].t0, 12)
         + env_comp_pkg::asr(st_ff[DL+2].t1, 13) + c_p7, 4);

      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            st_in[k].vld = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         st_ff[k] <= st_in[k];
      end
   end

   assign rsp_valid          = st_ff[NS-1].vld;
   assign rsp_temp_centi     = $signed(st_ff[NS-1].temp);
   assign rsp_press_pascal   = st_ff[NS-1].press;
   assign rsp_hum_milli      = st_ff[NS-1].hum;
   assign rsp_press_div_zero = st_ff[NS-1].flag;

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_press_div_zero |-> rsp_press_pascal == '0)
      else $error("pressure not forced to zero on a zero divisor");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hum_milli <= 17'd100000)
      else $error("humidity beyond its clamp");

   a_div_flow: assert property (@(posedge clock) disable iff (reset)
      st_ff[DF-1].vld |=> st_ff[DF].vld)
      else $error("transfer lost on entry to the divider");

   a_out_flow: assert property (@(posedge clock) disable iff (reset)
      st_ff[NS-2].vld |=> rsp_valid)
      else $error("transfer lost before the result strobe");

endmodule

// ===== sim/env_sensor_compensation_core_tb.sv =====
// ----------------------------------------------------------------------------
// Environmental sensor compensation core testbench
// Drives raw samples through the command port under several calibration sets,
// predicts temperature, pressure and humidity in 32-bit wrapping arithmetic
// and compares every result strobe with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module env_sensor_compensation_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 20000;

   typedef struct {
      logic [31:0] temp;
      logic [31:0] press;
      logic [16:0] hum;
      logic        div_zero;
   } sample_out_type;

   typedef struct {
      logic [19:0]    t;
      logic [19:0]    p;
      logic [15:0]    h;
      bit             typed;
      sample_out_type exp_out;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [19:0] req_raw_temp = '0;
   logic [19:0] req_raw_press = '0;
   logic [15:0] req_raw_hum = '0;
   logic        csr_we = 1'b0;
   logic [env_comp_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [env_comp_pkg::CsrDataWidth-1:0]  csr_wdata = '0;
   logic        rsp_valid;
   logic signed [31:0] rsp_temp_centi;
   logic [31:0] rsp_press_pascal;
   logic [16:0] rsp_hum_milli;
   logic        rsp_press_div_zero;

   logic [63:0]    calib [6];
   sample_out_type pending_results [$];
   int             mismatch_count = 0;
   int             quiet_cycles = 0;

   env_sensor_compensation_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_raw_temp(req_raw_temp), .req_raw_press(req_raw_press),
      .req_raw_hum(req_raw_hum), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .rsp_valid(rsp_valid), .rsp_temp_centi(rsp_temp_centi),
      .rsp_press_pascal(rsp_press_pascal), .rsp_hum_milli(rsp_hum_milli),
      .rsp_press_div_zero(rsp_press_div_zero)
   );

   always #6 clock = ~clock;

   function automatic logic [31:0] sra(input logic [31:0] x, input int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic sample_out_type compensate(input logic [19:0] raw_t,
                                                 input logic [19:0] raw_p,
                                                 input logic [15:0] raw_h);
      logic [31:0] adc_t, adc_p, adc_h;
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      logic [31:0] a, b, d, q, sq, fine, pp, c1, c2, sqp, v, x, y, z, e;
      sample_out_type r;
      adc_t = {12'd0, raw_t};
      adc_p = {12'd0, raw_p};
      adc_h = {16'd0, raw_h};
      t1 = {16'd0, calib[env_comp_pkg::REG_TEMP][15:0]};
      t2 = sx16(calib[env_comp_pkg::REG_TEMP][31:16]);
      t3 = sx16(calib[env_comp_pkg::REG_TEMP][47:32]);
      p1 = {16'd0, calib[env_comp_pkg::REG_PRESS_A][15:0]};
      p2 = sx16(calib[env_comp_pkg::REG_PRESS_A][31:16]);
      p3 = sx16(calib[env_comp_pkg::REG_PRESS_A][47:32]);
      p4 = sx16(calib[env_comp_pkg::REG_PRESS_A][63:48]);
      p5 = sx16(calib[env_comp_pkg::REG_PRESS_B][15:0]);
      p6 = sx16(calib[env_comp_pkg::REG_PRESS_B][31:16]);
      p7 = sx16(calib[env_comp_pkg::REG_PRESS_B][47:32]);
      p8 = sx16(calib[env_comp_pkg::REG_PRESS_B][63:48]);
      p9 = sx16(calib[env_comp_pkg::REG_PRESS_9][15:0]);
      h1 = {24'd0, calib[env_comp_pkg::REG_HUM_A][7:0]};
      h2 = sx16(calib[env_comp_pkg::REG_HUM_A][23:8]);
      h3 = {24'd0, calib[env_comp_pkg::REG_HUM_A][31:24]};
      h4 = {20'd0, calib[env_comp_pkg::REG_HUM_B][11:0]};
      h5 = {20'd0, calib[env_comp_pkg::REG_HUM_B][23:12]};
      h6 = {{24{calib[env_comp_pkg::REG_HUM_B][31]}}, calib[env_comp_pkg::REG_HUM_B][31:24]};

      a = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
      d = (adc_t >> 4) - t1;
      sq = d * d;
      b = sra(sra(sq, 12) * t3, 14);
      fine = a + b;
      r.temp = sra(fine * 32'd5 + 32'd128, 8);

      a = sra(fine, 1) - env_comp_pkg::PressOffset;
      q = sra(a, 2);
      sq = q * q;
      b = sra(sq, 11) * p6;
      b = b + ((a * p5) << 1);
      b = sra(b, 2) + (p4 << 16);
      a = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * a, 1), 18);
      a = sra((env_comp_pkg::HumBias + a) * p1, 15);
      if (a == 32'd0) begin
         r.press = 32'd0;
         r.div_zero = 1'b1;
      end else begin
         pp = (env_comp_pkg::PressBase - adc_p - sra(b, 12)) * env_comp_pkg::PressScale;
         if (pp < 32'h8000_0000) pp = (pp << 1) / a;
         else pp = (pp / a) * 32'd2;
         sqp = (pp >> 3) * (pp >> 3);
         c1 = sra(p9 * (sqp >> 13), 12);
         c2 = sra((pp >> 2) * p8, 13);
         r.press = pp + sra(c1 + c2 + p7, 4);
         r.div_zero = 1'b0;
      end

      v = fine - env_comp_pkg::HumOffset;
      x = (adc_h << 14) - (h4 << 20) - h5 * v + env_comp_pkg::HumRound;
      x = sra(x, 15);
      y = sra(sra(v * h6, 10) * (sra(v * h3, 11) + env_comp_pkg::HumBias), 10)
          + env_comp_pkg::HumY0;
      y = sra(y * h2 + env_comp_pkg::HumYRound, 14);
      z = x * y;
      e = sra(z, 15);
      sq = e * e;
      z = z - sra(sra(sq, 7) * h1, 4);
      if (z[31]) z = 32'd0;
      if (z > env_comp_pkg::HumMax) z = env_comp_pkg::HumMax;
      z = ((z >> 12) * 32'd1000) / 32'd1024;
      r.hum = z[16:0];
      return r;
   endfunction

   // Leaves csr_we high; the caller lowers it once the batch is done.
   task automatic csr_write(input int idx, input logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx[env_comp_pkg::CsrIndexWidth-1:0];
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         env_comp_pkg::REG_TEMP:    calib[idx] = val & 64'h0000_FFFF_FFFF_FFFF;
         env_comp_pkg::REG_PRESS_9: calib[idx] = val & 64'h0000_0000_0000_FFFF;
         env_comp_pkg::REG_HUM_A, env_comp_pkg::REG_HUM_B:
            calib[idx] = val & 64'h0000_0000_FFFF_FFFF;
         env_comp_pkg::REG_PRESS_A, env_comp_pkg::REG_PRESS_B: calib[idx] = val;
         default: ;
      endcase
   endtask

   task automatic load_calibration(input logic [63:0] vals [6]);
      for (int i = 0; i < 6; i++) csr_write(i, vals[i]);
      csr_write(6, {$urandom, $urandom});
      csr_write(7, {$urandom, $urandom});
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic [19:0] t, input logic [19:0] p,
                              input logic [15:0] h, input bit typed,
                              input sample_out_type exp_out);
      start <= 1'b1;
      req_raw_temp <= t;
      req_raw_press <= p;
      req_raw_hum <= h;
      do @(posedge clock); while (busy);
      pending_results.push_back(typed ? exp_out : compensate(t, p, h));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      sample_out_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected transfer: temp %0d press %0d hum %0d flag %0b",
                        rsp_temp_centi, rsp_press_pascal, rsp_hum_milli,
                        rsp_press_div_zero);
         end else begin
            want = pending_results.pop_front();
            if (rsp_temp_centi !== want.temp || rsp_press_pascal !== want.press ||
                rsp_hum_milli !== want.hum || rsp_press_div_zero !== want.div_zero) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: temp %0d/%0d press %0d/%0d hum %0d/%0d flag %0b/%0b",
                           $signed(want.temp), rsp_temp_centi, want.press,
                           rsp_press_pascal, want.hum, rsp_hum_milli,
                           want.div_zero, rsp_press_div_zero);
            end
         end
      end
   end

   initial begin
      stim_row_type   rows [$];
      logic [63:0]    typical [6];
      logic [63:0]    cal [6];
      sample_out_type at_reset;
      sample_out_type none;
      logic [19:0]    t, p;
      logic [15:0]    h;
      int             burst, gap, sent;
      at_reset = '{32'd0, 32'd0, 17'd0, 1'b1};
      none = '{32'd0, 32'd0, 17'd0, 1'b0};
      for (int i = 0; i < 6; i++) calib[i] = '0;
      typical[env_comp_pkg::REG_TEMP]    = {16'hFC18, 16'd26435, 16'd27504};
      typical[env_comp_pkg::REG_PRESS_A] = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
      typical[env_comp_pkg::REG_PRESS_B] = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
      typical[env_comp_pkg::REG_PRESS_9] = 64'd6000;
      typical[env_comp_pkg::REG_HUM_A]   = {8'd0, 16'd362, 8'd75};
      typical[env_comp_pkg::REG_HUM_B]   = {8'd30, 12'd50, 12'd313};

      rows.push_back('{20'd0, 20'd0, 16'd0, 1'b1, at_reset});
      rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, at_reset});
      rows.push_back('{20'h55555, 20'hAAAAA, 16'h5A5A, 1'b1, at_reset});
      rows.push_back('{20'd519888, 20'd415148, 16'd27000, 1'b0, none});
      rows.push_back('{20'd0, 20'd415148, 16'd27000, 1'b0, none});
      rows.push_back('{20'hFFFFF, 20'd415148, 16'd27000, 1'b0, none});
      rows.push_back('{20'd519888, 20'd0, 16'd27000, 1'b0, none});
      rows.push_back('{20'd519888, 20'hFFFFF, 16'd27000, 1'b0, none});
      rows.push_back('{20'd519888, 20'd415148, 16'd0, 1'b0, none});
      rows.push_back('{20'd519888, 20'd415148, 16'hFFFF, 1'b0, none});
      rows.push_back('{20'd0, 20'd0, 16'd0, 1'b0, none});
      rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, none});
      rows.push_back('{20'd440000, 20'd300000, 16'd40000, 1'b0, none});
      rows.push_back('{20'd600000, 20'd500000, 16'd15000, 1'b0, none});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (!rows[i].typed && (i == 0 || rows[i-1].typed)) begin
            drain_results();
            load_calibration(typical);
         end
         send_sample(rows[i].t, rows[i].p, rows[i].h, rows[i].typed, rows[i].exp_out);
      end

      for (int ph = 0; ph < 8; ph++) begin
         drain_results();
         for (int i = 0; i < 6; i++) begin
            case (ph)
               0: cal[i] = '1;
               1: cal[i] = typical[i] & ~64'h0000_0000_0000_FFFF;
               2, 5: cal[i] = typical[i] ^ {$urandom, $urandom} & 64'h00FF_00FF_00FF_003F;
               default: cal[i] = {$urandom, $urandom};
            endcase
         end
         load_calibration(cal);
         sent = 0;
         while (sent < 190) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst; k++) begin
               if ($urandom_range(0, 1)) begin
                  t = 20'($urandom);
                  p = 20'($urandom);
                  h = 16'($urandom);
               end else begin
                  t = 20'($urandom_range(480000, 560000));
                  p = 20'($urandom_range(250000, 450000));
                  h = 16'($urandom_range(20000, 40000));
               end
               send_sample(t, p, h, 1'b0, none);
               sent++;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      drain_results();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
